/* hw/rtl/wrse_pkg.sv */
package wrse_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int RELAY_SLOTS_DEF   = 20;
    localparam int WEEK_MINUTES      = 7 * 24 * 60;
    localparam int DAY_MINUTES       = 1440;
    localparam int MAX_FIRED         = 32;
    localparam int RELAY_W           = 20;
    localparam int IDX_MAX_W         = 8;
    localparam int ENTRY_W           = 73;

    localparam logic [4:0]  FITTED_RST   = 5'd2;
    localparam logic [19:0] PRESENT_RST  = 20'd0;
    localparam logic [13:0] CATCH_UP_RST = 14'd180;

    localparam logic [13:0] WEEK_C = 14'(WEEK_MINUTES);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] CFG_FITTED   = 2'd0;
    localparam logic [1:0] CFG_PRESENT  = 2'd1;
    localparam logic [1:0] CFG_CATCH_UP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } wrse_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  entry_index;
        logic [30:0] event_id;
        logic [4:0]  target_relay;
        logic [2:0]  weekday;
        logic [13:0] time_value;
        logic        turn_on;
        logic        is_dated;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic        clock_valid;
    } wrse_in_t;

    typedef struct packed {
        logic [4:0]  relay_number;
        logic        switch_on;
        logic [30:0] fired_id;
        logic [19:0] relay_states;
        logic        last_of_tick;
    } wrse_out_t;

    // sort key: position, id, off before on reversed (on first), slot
    typedef struct packed {
        logic [13:0]          pos;
        logic [30:0]          sid;
        logic                 off;
        logic [IDX_MAX_W-1:0] idx;
    } wrse_key_t;

    typedef struct packed {
        logic [13:0] prev;
        logic [13:0] delta;
        logic [2:0]  wday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
        logic [4:0]  fitted;
        logic [19:0] present;
    } wrse_ctx_t;

    typedef struct packed {
        logic        v;
        logic        ok;
        wrse_key_t   key;
        logic [4:0]  relay;
    } wrse_cand_t;

    function automatic logic [13:0] day_base(input logic [2:0] d);
        logic [13:0] r;
        begin
            case (d)
                3'd0:    r = 14'd0;
                3'd1:    r = 14'd1440;
                3'd2:    r = 14'd2880;
                3'd3:    r = 14'd4320;
                3'd4:    r = 14'd5760;
                3'd5:    r = 14'd7200;
                3'd6:    r = 14'd8640;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] week_day(input logic [13:0] m);
        logic [2:0] r;
        begin
            if (m < 14'd1440)      r = 3'd0;
            else if (m < 14'd2880) r = 3'd1;
            else if (m < 14'd4320) r = 3'd2;
            else if (m < 14'd5760) r = 3'd3;
            else if (m < 14'd7200) r = 3'd4;
            else if (m < 14'd8640) r = 3'd5;
            else                   r = 3'd6;
            return r;
        end
    endfunction

endpackage

/* hw/rtl/wrse_if.sv */
interface wrse_in_if;
    import wrse_pkg::*;
    logic     valid;
    logic     ready;
    wrse_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wrse_out_if;
    import wrse_pkg::*;
    logic      valid;
    logic      ready;
    wrse_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/weekly_relay_schedule_executor.sv */
// Weekly relay schedule executor. Items on "items" are clear, write-entry or
// minute-tick beats; one beat is taken at a time, and items.ready is low while
// a tick is worked on. A tick that reaches the 32-event cap skips the final
// empty pass; an output stall holds the tick up. Every result needs one full
// pass over all entry/weekday pairs, read one pair per cycle from the table
// RAM and ranked by one shared key comparator, which picks the smallest key
// above the last one fired. Results leave through an output register on
// "results"; the last result of a tick carries last_of_tick. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while idle, and the block itself does not enforce this.
module weekly_relay_schedule_executor #(
    parameter int TABLE_ENTRIES = wrse_pkg::TABLE_ENTRIES_DEF,
    parameter int RELAY_SLOTS   = wrse_pkg::RELAY_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data,
    wrse_in_if.sink      items,
    wrse_out_if.source   results
);
    import wrse_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // configuration
    logic [4:0]  fitted_reg;
    logic [19:0] present_reg;
    logic [13:0] catch_up_reg;

    // control state
    wrse_state_t              state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [13:0]              prev_reg, prev_next;
    logic                     known_reg, known_next;
    logic [RELAY_W-1:0]       relay_bits_reg, relay_bits_next;
    logic [IDX_W-1:0]         iss_idx_reg, iss_idx_next;
    logic [2:0]               iss_day_reg, iss_day_next;
    logic                     iss_done_reg, iss_done_next;
    logic                     best_v_reg, best_v_next;
    logic                     last_v_reg, last_v_next;
    logic [5:0]               fired_reg, fired_next;
    logic                     pend_v_reg, pend_v_next;
    logic                     ov_reg, ov_next;

    // payload
    logic [13:0] mow_reg, mow_next;
    logic [13:0] delta_reg, delta_next;
    logic [2:0]  wday_reg, wday_next;
    logic [11:0] ty_reg, ty_next;
    logic [3:0]  tm_reg, tm_next;
    logic [4:0]  td_reg, td_next;
    wrse_key_t   best_key_reg, best_key_next;
    logic [4:0]  best_relay_reg, best_relay_next;
    wrse_key_t   last_key_reg, last_key_next;
    wrse_out_t   pend_reg, pend_next;
    wrse_out_t   od_reg, od_next;

    // table
    logic             ram_we;
    logic [8:0]       slot_ext;
    logic [IDX_W-1:0] slot;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    assign slot_ext  = {4'd0, items.data.entry_index};
    assign slot      = slot_ext[IDX_W-1:0];
    assign ram_wdata = {items.data.year, items.data.month, items.data.day_of_month,
                        items.data.weekday, items.data.time_value[10:0],
                        items.data.is_dated, items.data.turn_on,
                        items.data.target_relay, items.data.event_id};

    wrse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (iss_idx_reg),
        .rdata (ram_rdata)
    );

    // candidate pipeline
    wrse_ctx_t  ctx;
    wrse_cand_t cand;
    logic       cand_busy;
    logic       issue_v;

    assign ctx.prev    = prev_reg;
    assign ctx.delta   = delta_reg;
    assign ctx.wday    = wday_reg;
    assign ctx.year    = ty_reg;
    assign ctx.month   = tm_reg;
    assign ctx.dom     = td_reg;
    assign ctx.fitted  = fitted_reg;
    assign ctx.present = present_reg;

    assign issue_v = (state_reg == ST_SCAN) && !iss_done_reg;

    wrse_cand #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .RELAY_SLOTS   (RELAY_SLOTS),
        .IDX_W         (IDX_W)
    ) u_cand (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue_v    (issue_v),
        .issue_idx  (iss_idx_reg),
        .issue_day  (iss_day_reg),
        .rdata      (ram_rdata),
        .valid_bits (valid_reg),
        .ctx        (ctx),
        .cand       (cand),
        .busy       (cand_busy)
    );

    // shared key comparator: above the last fired key, below the best so far
    logic gt_last;
    logic lt_best;

    assign gt_last = !last_v_reg || (cand.key > last_key_reg);
    assign lt_best = !best_v_reg || (cand.key < best_key_reg);

    assign items.ready   = (state_reg == ST_IDLE);
    assign results.valid = ov_reg;
    assign results.data  = od_reg;

    logic [13:0]        mow_in;
    logic [13:0]        delta_c;
    logic [4:0]         rm1;
    logic [RELAY_W-1:0] rbit;
    logic [RELAY_W-1:0] bits_new;

    assign mow_in = (items.data.time_value >= WEEK_C)
                    ? (items.data.time_value - WEEK_C) : items.data.time_value;
    assign delta_c = (mow_reg >= prev_reg) ? (mow_reg - prev_reg)
                     : 14'(mow_reg + WEEK_C - prev_reg);
    assign rm1      = best_relay_reg - 5'd1;
    assign rbit     = RELAY_W'(1) << rm1;
    assign bits_new = best_key_reg.off ? (relay_bits_reg & ~rbit) : (relay_bits_reg | rbit);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        prev_next       = prev_reg;
        known_next      = known_reg;
        relay_bits_next = relay_bits_reg;
        iss_idx_next    = iss_idx_reg;
        iss_day_next    = iss_day_reg;
        iss_done_next   = iss_done_reg;
        best_v_next     = best_v_reg;
        last_v_next     = last_v_reg;
        fired_next      = fired_reg;
        pend_v_next     = pend_v_reg;
        ov_next         = ov_reg && !results.ready;
        mow_next        = mow_reg;
        delta_next      = delta_reg;
        wday_next       = wday_reg;
        ty_next         = ty_reg;
        tm_next         = tm_reg;
        td_next         = td_reg;
        best_key_next   = best_key_reg;
        best_relay_next = best_relay_reg;
        last_key_next   = last_key_reg;
        pend_next       = pend_reg;
        od_next         = od_reg;
        ram_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    case (items.data.action)
                        ACT_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        ACT_WRITE:
                        begin
                            if (slot_ext < 9'(TABLE_ENTRIES))
                            begin
                                ram_we           = 1'b1;
                                valid_next[slot] = 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (items.data.clock_valid)
                            begin
                                mow_next   = mow_in;
                                ty_next    = items.data.year;
                                tm_next    = items.data.month;
                                td_next    = items.data.day_of_month;
                                state_next = ST_PREP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PREP:
            begin
                state_next = ST_IDLE;
                if (!known_reg)
                begin
                    prev_next  = mow_reg;
                    known_next = 1'b1;
                end
                else if (delta_c > catch_up_reg)
                begin
                    prev_next = mow_reg;
                end
                else if (delta_c != 14'd0)
                begin
                    delta_next    = delta_c;
                    wday_next     = week_day(mow_reg);
                    iss_idx_next  = '0;
                    iss_day_next  = 3'd0;
                    iss_done_next = 1'b0;
                    best_v_next   = 1'b0;
                    last_v_next   = 1'b0;
                    fired_next    = 6'd0;
                    pend_v_next   = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (!iss_done_reg)
                begin
                    if (iss_day_reg == 3'd6)
                    begin
                        iss_day_next = 3'd0;
                        if (iss_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                        begin
                            iss_done_next = 1'b1;
                        end
                        else
                        begin
                            iss_idx_next = iss_idx_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        iss_day_next = iss_day_reg + 3'd1;
                    end
                end
                if (cand.v && cand.ok && gt_last && lt_best)
                begin
                    best_v_next     = 1'b1;
                    best_key_next   = cand.key;
                    best_relay_next = cand.relay;
                end
                if (iss_done_reg && !cand_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (best_v_reg)
                begin
                    // the previous result is not the last one: send it first
                    if (!(pend_v_reg && ov_reg))
                    begin
                        if (pend_v_reg)
                        begin
                            ov_next = 1'b1;
                            od_next = pend_reg;
                        end
                        relay_bits_next        = bits_new;
                        pend_v_next            = 1'b1;
                        pend_next.relay_number = best_relay_reg;
                        pend_next.switch_on    = !best_key_reg.off;
                        pend_next.fired_id     = best_key_reg.sid;
                        pend_next.relay_states = bits_new;
                        pend_next.last_of_tick = 1'b0;
                        fired_next             = fired_reg + 6'd1;
                        if (fired_reg == 6'(MAX_FIRED - 1))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            last_v_next   = 1'b1;
                            last_key_next = best_key_reg;
                            best_v_next   = 1'b0;
                            iss_idx_next  = '0;
                            iss_day_next  = 3'd0;
                            iss_done_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
                else if (pend_v_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    prev_next  = mow_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (!ov_reg)
                begin
                    ov_next              = 1'b1;
                    od_next              = pend_reg;
                    od_next.last_of_tick = 1'b1;
                    pend_v_next          = 1'b0;
                    prev_next            = mow_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            prev_reg       <= 14'd0;
            known_reg      <= 1'b0;
            relay_bits_reg <= '0;
            iss_idx_reg    <= '0;
            iss_day_reg    <= 3'd0;
            iss_done_reg   <= 1'b1;
            best_v_reg     <= 1'b0;
            last_v_reg     <= 1'b0;
            fired_reg      <= 6'd0;
            pend_v_reg     <= 1'b0;
            ov_reg         <= 1'b0;
            fitted_reg     <= FITTED_RST;
            present_reg    <= PRESENT_RST;
            catch_up_reg   <= CATCH_UP_RST;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            prev_reg       <= prev_next;
            known_reg      <= known_next;
            relay_bits_reg <= relay_bits_next;
            iss_idx_reg    <= iss_idx_next;
            iss_day_reg    <= iss_day_next;
            iss_done_reg   <= iss_done_next;
            best_v_reg     <= best_v_next;
            last_v_reg     <= last_v_next;
            fired_reg      <= fired_next;
            pend_v_reg     <= pend_v_next;
            ov_reg         <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FITTED:   fitted_reg   <= cfg_data[4:0];
                    CFG_PRESENT:  present_reg  <= cfg_data;
                    CFG_CATCH_UP: catch_up_reg <= cfg_data[13:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mow_reg        <= mow_next;
        delta_reg      <= delta_next;
        wday_reg       <= wday_next;
        ty_reg         <= ty_next;
        tm_reg         <= tm_next;
        td_reg         <= td_next;
        best_key_reg   <= best_key_next;
        best_relay_reg <= best_relay_next;
        last_key_reg   <= last_key_next;
        pend_reg       <= pend_next;
        od_reg         <= od_next;
    end
endmodule

/* hw/rtl/wrse_ram.sv */
module wrse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/wrse_cand.sv */
module wrse_cand #(
    parameter int TABLE_ENTRIES = wrse_pkg::TABLE_ENTRIES_DEF,
    parameter int RELAY_SLOTS   = wrse_pkg::RELAY_SLOTS_DEF,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         issue_v,
    input  logic [IDX_W-1:0]             issue_idx,
    input  logic [2:0]                   issue_day,
    input  logic [wrse_pkg::ENTRY_W-1:0] rdata,
    input  logic [TABLE_ENTRIES-1:0]     valid_bits,
    input  wrse_pkg::wrse_ctx_t          ctx,
    output wrse_pkg::wrse_cand_t         cand,
    output logic                         busy
);
    import wrse_pkg::*;

    logic             s1_v_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [2:0]       s1_day_reg;

    logic             s2_v_reg;
    logic             s2_elig_reg;
    logic [13:0]      s2_evm_reg;
    logic [30:0]      s2_sid_reg;
    logic             s2_on_reg;
    logic [4:0]       s2_relay_reg;
    logic [IDX_W-1:0] s2_idx_reg;

    logic             s3_v_reg;
    wrse_cand_t       s3_reg;

    // stage 1: decode the entry read from the table
    logic [30:0] sid;
    logic [4:0]  relay;
    logic        on;
    logic        dated;
    logic [10:0] minute;
    logic [2:0]  wd;
    logic [4:0]  e_dom;
    logic [3:0]  e_month;
    logic [11:0] e_year;
    logic        day_ok;
    logic [13:0] ev;
    logic [13:0] evm;
    logic [4:0]  rm1;
    logic [31:0] mask_sh;
    logic        usable;
    logic        elig;

    assign sid     = rdata[30:0];
    assign relay   = rdata[35:31];
    assign on      = rdata[36];
    assign dated   = rdata[37];
    assign minute  = rdata[48:38];
    assign wd      = rdata[51:49];
    assign e_dom   = rdata[56:52];
    assign e_month = rdata[60:57];
    assign e_year  = rdata[72:61];

    assign rm1     = relay - 5'd1;
    assign mask_sh = {12'd0, ctx.present} >> rm1;

    always_comb
    begin
        if (dated)
        begin
            day_ok = (s1_day_reg == 3'd0) && (e_year == ctx.year)
                     && (e_month == ctx.month) && (e_dom == ctx.dom);
            ev     = day_base(ctx.wday) + 14'(minute);
        end
        else
        begin
            day_ok = (wd == 3'd0) || (wd == (s1_day_reg + 3'd1));
            ev     = day_base(s1_day_reg) + 14'(minute);
        end
        evm    = (ev >= WEEK_C) ? (ev - WEEK_C) : ev;
        usable = (relay != 5'd0) && (relay <= ctx.fitted)
                 && ({1'b0, relay} <= 6'(RELAY_SLOTS)) && mask_sh[0];
        elig   = valid_bits[s1_idx_reg] && day_ok && usable;
    end

    // stage 2: position in the window
    logic [13:0] from;
    logic        in_win;

    always_comb
    begin
        if (s2_evm_reg >= ctx.prev)
        begin
            from = s2_evm_reg - ctx.prev;
        end
        else
        begin
            from = 14'(s2_evm_reg + WEEK_C - ctx.prev);
        end
        in_win = (from != 14'd0) && (from <= ctx.delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue_v;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= issue_idx;
        s1_day_reg     <= issue_day;
        s2_elig_reg    <= elig;
        s2_evm_reg     <= evm;
        s2_sid_reg     <= sid;
        s2_on_reg      <= on;
        s2_relay_reg   <= relay;
        s2_idx_reg     <= s1_idx_reg;
        s3_reg.v       <= 1'b1;
        s3_reg.ok      <= s2_elig_reg && in_win;
        s3_reg.key.pos <= from;
        s3_reg.key.sid <= s2_sid_reg;
        s3_reg.key.off <= !s2_on_reg;
        s3_reg.key.idx <= IDX_MAX_W'(s2_idx_reg);
        s3_reg.relay   <= s2_relay_reg;
    end

    always_comb
    begin
        cand   = s3_reg;
        cand.v = s3_v_reg;
    end

    assign busy = s1_v_reg || s2_v_reg || s3_v_reg;
endmodule
